### design/ecd_pkg.sv
package ecd_pkg;

  // pipeline depth, one flag per register stage
  localparam int NStages = 9;

  localparam logic [11:0] BaseYear = 12'd1970;

  // ceil(2^35 / 15): (x >> 2) * this >> 35 gives x / 60 for any 32-bit x
  localparam logic [31:0] MinRecip = 32'h8888_8889;

  // ceil(2^30 / 4383): (h >> 3) * this >> 30 gives h / 35064 for h < 2^21
  localparam logic [17:0] QuadRecip = 18'd244979;
  localparam logic [20:0] HoursPerQuad = 21'd35064;

  // hour offsets of the 2nd, 3rd and 4th year of a four-year block from 1970
  // (common, common, leap, common)
  localparam logic [15:0] YearStart1 = 16'd8760;
  localparam logic [15:0] YearStart2 = 16'd17520;
  localparam logic [15:0] YearStart3 = 16'd26304;

  // ceil(2^12 / 3): (y >> 3) * this >> 12 gives y / 24 for y < 8784
  localparam logic [10:0] DayRecip = 11'd1366;

  localparam logic [8:0] LeapDayOfYear = 9'd60;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [4:0] DayLeap = 5'd29;

  typedef struct packed {
    logic [5:0]  sec;
    logic [26:0] min_total;
    logic [20:0] hours;
  } time_part_t;

  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [11:0] year;
    logic        leap;
    logic [13:0] hour_of_year;
  } year_part_t;

  // days before the first of month idx (0 = January), common year
  function automatic logic [8:0] cum_start(input logic [3:0] idx);
    logic [8:0] r;
    unique case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

### design/ecd_time_split.sv
module ecd_time_split import ecd_pkg::*; (
  input  logic               clk_i,
  input  logic [2:0]         en_i,
  input  logic [31:0]        epoch_seconds_i,
  input  logic signed [16:0] zone_offset_i,
  output time_part_t         res_o
);

  logic [31:0] sum0_q, sum0_d;
  logic [31:0] sum1_q;
  logic [26:0] min1_q, min1_d;
  logic [61:0] prod1;
  logic [56:0] prod2;
  logic [5:0]  sec2_q, sec2_d;
  logic [26:0] min2_q;
  logic [20:0] hrs2_q, hrs2_d;

  // offset add, wraps mod 2^32
  assign sum0_d = epoch_seconds_i + {{15{zone_offset_i[16]}}, zone_offset_i};

  // total minutes
  assign prod1  = 62'(sum0_q[31:2]) * 62'(MinRecip);
  assign min1_d = prod1[61:35];

  // t - 60q == t + 4q (mod 64), and the true value is below 60
  assign sec2_d = sum1_q[5:0] + {min1_q[3:0], 2'b00};
  assign prod2  = 57'(min1_q[26:2]) * 57'(MinRecip);
  assign hrs2_d = prod2[55:35];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sum0_q <= sum0_d;
    end
    if (en_i[1]) begin
      sum1_q <= sum0_q;
      min1_q <= min1_d;
    end
    if (en_i[2]) begin
      sec2_q <= sec2_d;
      min2_q <= min1_q;
      hrs2_q <= hrs2_d;
    end
  end

  assign res_o.sec       = sec2_q;
  assign res_o.min_total = min2_q;
  assign res_o.hours     = hrs2_q;

endmodule

### design/ecd_year_split.sv
module ecd_year_split import ecd_pkg::*; (
  input  logic       clk_i,
  input  logic [2:0] en_i,
  input  time_part_t tp_i,
  output year_part_t res_o
);

  logic [35:0] prod3;
  logic [5:0]  quad3_q, quad3_d;
  logic [20:0] hrs3_q;
  logic [5:0]  sec3_q, min3_q, min3_d;

  logic [15:0] hq4_q, hq4_d;
  logic [11:0] yb4_q, yb4_d;
  logic [5:0]  sec4_q, min4_q;

  logic [1:0]  yidx;
  logic [15:0] ystart;
  logic [13:0] hy5_q, hy5_d;
  logic [11:0] year5_q, year5_d;
  logic        leap5_q, leap5_d;
  logic [5:0]  sec5_q, min5_q;

  // minutes: m - 60h == m + 4h (mod 64)
  assign min3_d  = tp_i.min_total[5:0] + {tp_i.hours[3:0], 2'b00};
  // number of whole four-year blocks
  assign prod3   = 36'(tp_i.hours[20:3]) * 36'(QuadRecip);
  assign quad3_d = prod3[35:30];

  assign hq4_d = 16'(hrs3_q - 21'(quad3_q) * HoursPerQuad);
  assign yb4_d = BaseYear + {4'b0000, quad3_q, 2'b00};

  always_comb begin
    priority if (hq4_q >= YearStart3) begin
      yidx   = 2'd3;
      ystart = YearStart3;
    end else if (hq4_q >= YearStart2) begin
      yidx   = 2'd2;
      ystart = YearStart2;
    end else if (hq4_q >= YearStart1) begin
      yidx   = 2'd1;
      ystart = YearStart1;
    end else begin
      yidx   = 2'd0;
      ystart = 16'd0;
    end
  end

  assign hy5_d   = 14'(hq4_q - ystart);
  assign year5_d = yb4_q + {10'd0, yidx};
  // block starts at a year == 2 (mod 4), so its third year is the leap one
  assign leap5_d = (yidx == 2'd2);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      quad3_q <= quad3_d;
      hrs3_q  <= tp_i.hours;
      sec3_q  <= tp_i.sec;
      min3_q  <= min3_d;
    end
    if (en_i[1]) begin
      hq4_q  <= hq4_d;
      yb4_q  <= yb4_d;
      sec4_q <= sec3_q;
      min4_q <= min3_q;
    end
    if (en_i[2]) begin
      hy5_q   <= hy5_d;
      year5_q <= year5_d;
      leap5_q <= leap5_d;
      sec5_q  <= sec4_q;
      min5_q  <= min4_q;
    end
  end

  assign res_o.sec          = sec5_q;
  assign res_o.min          = min5_q;
  assign res_o.year         = year5_q;
  assign res_o.leap         = leap5_q;
  assign res_o.hour_of_year = hy5_q;

endmodule

### design/ecd_date_split.sv
module ecd_date_split import ecd_pkg::*; (
  input  logic        clk_i,
  input  logic [2:0]  en_i,
  input  year_part_t  yp_i,
  output logic [5:0]  second_of_minute_o,
  output logic [5:0]  minute_of_hour_o,
  output logic [4:0]  hour_of_day_o,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_number_o,
  output logic [11:0] year_number_o
);

  logic [21:0] prod6;
  logic [9:0]  dq;
  logic [8:0]  doy6_q, doy6_d;
  logic [4:0]  hour6_q, hour6_d;
  logic        leap6_q;
  logic [11:0] year6_q, year7_q;
  logic [5:0]  sec6_q, min6_q, sec7_q, min7_q;
  logic [4:0]  hour7_q;

  logic [8:0]  dadj7_q, dadj7_d;
  logic [3:0]  midx7_q, midx7_d;
  logic        feb29_7_q, feb29_7_d;

  logic [4:0]  day8_q, day8_d;
  logic [3:0]  mon8_q, mon8_d;
  logic [5:0]  sec8_q, min8_q;
  logic [4:0]  hour8_q;
  logic [11:0] year8_q;

  // day of year and hour of day
  assign prod6   = 22'(yp_i.hour_of_year[13:3]) * 22'(DayRecip);
  assign dq      = prod6[21:12];
  assign hour6_d = 5'(yp_i.hour_of_year - ({dq, 4'b0000} + {1'b0, dq, 3'b000}));
  assign doy6_d  = dq[8:0] + 9'd1;

  // fold out the leap day, then count month ends passed
  assign feb29_7_d = leap6_q && (doy6_q == LeapDayOfYear);
  assign dadj7_d   = (leap6_q && (doy6_q > LeapDayOfYear)) ? doy6_q - 9'd1 : doy6_q;

  always_comb begin
    midx7_d = 4'd0;
    for (int i = 0; i < 11; i++) begin
      midx7_d = midx7_d + 4'((cum_start(4'(i + 1)) < dadj7_d) ? 1 : 0);
    end
  end

  always_comb begin
    if (feb29_7_q) begin
      day8_d = DayLeap;
      mon8_d = MonthFeb;
    end else begin
      day8_d = 5'(dadj7_q - cum_start(midx7_q));
      mon8_d = midx7_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      doy6_q  <= doy6_d;
      hour6_q <= hour6_d;
      leap6_q <= yp_i.leap;
      year6_q <= yp_i.year;
      sec6_q  <= yp_i.sec;
      min6_q  <= yp_i.min;
    end
    if (en_i[1]) begin
      dadj7_q   <= dadj7_d;
      midx7_q   <= midx7_d;
      feb29_7_q <= feb29_7_d;
      hour7_q   <= hour6_q;
      year7_q   <= year6_q;
      sec7_q    <= sec6_q;
      min7_q    <= min6_q;
    end
    if (en_i[2]) begin
      day8_q  <= day8_d;
      mon8_q  <= mon8_d;
      hour8_q <= hour7_q;
      year8_q <= year7_q;
      sec8_q  <= sec7_q;
      min8_q  <= min7_q;
    end
  end

  assign second_of_minute_o = sec8_q;
  assign minute_of_hour_o   = min8_q;
  assign hour_of_day_o      = hour8_q;
  assign day_of_month_o     = day8_q;
  assign month_number_o     = mon8_q;
  assign year_number_o      = year8_q;

endmodule

### design/epoch_to_calendar_date_unit.sv
// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_stall_o    epoch_seconds_i
// output    out        out_valid_o / out_stall_i  second, minute, hour, day, month, year
// config    in         cfg_we_i                   cfg_wdata_i (zone offset, signed)
//
// Nine register stages; one item per cycle while out_stall_i does not hold the output.
// The depth is set by the offset add, the two reciprocal multiplies for /60 and the one for /35064,
// each followed by a register, plus the block remainder, year selection, /24 and month and day stages.
// Reset clears the stage valid flags and loads the zone offset with 28800.
// A stall holds only the stages that are full behind it; empty stages still fill.

module epoch_to_calendar_date_unit import ecd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic signed [16:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        epoch_seconds_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         second_of_minute_o,
  output logic [5:0]         minute_of_hour_o,
  output logic [4:0]         hour_of_day_o,
  output logic [4:0]         day_of_month_o,
  output logic [3:0]         month_number_o,
  output logic [11:0]        year_number_o
);

  logic signed [16:0]   zone_q;
  logic [NStages-1:0]   valid_q, valid_d;
  logic [NStages-1:0]   en;
  time_part_t           tp;
  year_part_t           yp;

  // zone offset register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q <= 17'sd28800;
    end else if (cfg_we_i) begin
      zone_q <= cfg_wdata_i;
    end
  end

  // A stage loads when it is empty or the stage after it moves on.
  always_comb begin
    en[NStages-1] = !valid_q[NStages-1] || !out_stall_i;
    for (int k = NStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < NStages; k++) begin
      if (en[k]) begin
        valid_d[k] = (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k - 1];
      end else begin
        valid_d[k] = valid_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[NStages-1];

  // stages 0..2: offset add, seconds, minutes, hours
  ecd_time_split u_time (
    .clk_i           (clk_i),
    .en_i            (en[2:0]),
    .epoch_seconds_i (epoch_seconds_i),
    .zone_offset_i   (zone_q),
    .res_o           (tp)
  );

  // stages 3..5: four-year blocks, year, hour within year
  ecd_year_split u_year (
    .clk_i (clk_i),
    .en_i  (en[5:3]),
    .tp_i  (tp),
    .res_o (yp)
  );

  // stages 6..8: hour of day, day of year, month and day; last stage is the output register
  ecd_date_split u_date (
    .clk_i              (clk_i),
    .en_i               (en[8:6]),
    .yp_i               (yp),
    .second_of_minute_o (second_of_minute_o),
    .minute_of_hour_o   (minute_of_hour_o),
    .hour_of_day_o      (hour_of_day_o),
    .day_of_month_o     (day_of_month_o),
    .month_number_o     (month_number_o),
    .year_number_o      (year_number_o)
  );

endmodule

### bench/calendar_date_checker.sv
`timescale 1ns / 100ps

module calendar_date_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic signed [16:0] cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [31:0]        epoch_seconds_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [5:0]         second_of_minute_i,
  input  logic [5:0]         minute_of_hour_i,
  input  logic [4:0]         hour_of_day_i,
  input  logic [4:0]         day_of_month_i,
  input  logic [3:0]         month_number_i,
  input  logic [11:0]        year_number_i,
  output int                 errors_o,
  output int                 pending_o
);

  localparam logic [31:0] HoursPerQuad = 32'd35064;  // 1461 days
  localparam logic [31:0] HoursPerYear = 32'd8760;   // 365 days

  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } calendar_t;

  typedef struct packed {
    logic [31:0] epoch;
    calendar_t   date;
  } dated_item_t;

  dated_item_t       dates_due [$];
  logic signed [16:0] zone_offset = 17'sd28800;
  int                errors = 0;
  int                pending = 0;

  assign errors_o  = errors;
  assign pending_o = pending;

  // local wall-clock date for one epoch count under the given zone offset
  function automatic calendar_t local_calendar(input logic [31:0] epoch,
                                               input logic signed [16:0] zone);
    logic [31:0] t;
    logic [31:0] year;
    logic [31:0] len;
    logic [31:0] day;
    logic [31:0] mon;
    logic        found;
    calendar_t   c;
    t = epoch + {{15{zone[16]}}, zone};
    c.sec = 6'(t % 60);
    t = t / 60;
    c.min = 6'(t % 60);
    t = t / 60;
    year = 32'd1970 + 32'd4 * (t / HoursPerQuad);
    t = t % HoursPerQuad;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!found) begin
        len = HoursPerYear + ((year[1:0] == 2'd0) ? 32'd24 : 32'd0);
        if (t < len) begin
          found = 1'b1;
        end else begin
          year = year + 1;
          t = t - len;
        end
      end
    end
    c.hour = 5'(t % 24);
    day = t / 24 + 1;
    mon = 0;
    if (year[1:0] == 2'd0 && day == 60) begin
      // leap day
      mon = 2;
      day = 29;
    end else begin
      if (year[1:0] == 2'd0 && day > 60) day = day - 1;
      found = 1'b0;
      for (int m = 0; m < 11; m++) begin
        if (!found) begin
          // 31/30 alternate, phase flips at August; February is 28 here
          len = (mon == 1) ? 32'd28 : 32'd31 - ((mon + (mon >= 7)) & 32'd1);
          if (day <= len) begin
            found = 1'b1;
          end else begin
            day = day - len;
            mon = mon + 1;
          end
        end
      end
      mon = mon + 1;
    end
    c.day   = 5'(day);
    c.month = 4'(mon);
    c.year  = 12'(year);
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dated_item_t want;
    calendar_t   got;
    if (!rst_ni) begin
      zone_offset = 17'sd28800;
      dates_due.delete();
      pending = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{second_of_minute_i, minute_of_hour_i, hour_of_day_i,
                day_of_month_i, month_number_i, year_number_i};
        if (dates_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected item %0d-%0d-%0d %0d:%0d:%0d", $time,
                   got.year, got.month, got.day, got.hour, got.min, got.sec);
        end else begin
          want = dates_due.pop_front();
          if (got.sec !== want.date.sec || got.min !== want.date.min ||
              got.hour !== want.date.hour || got.day !== want.date.day ||
              got.month !== want.date.month || got.year !== want.date.year) begin
            errors++;
            $display("%0t: epoch %0d expected %0d-%0d-%0d %0d:%0d:%0d got %0d-%0d-%0d %0d:%0d:%0d",
                     $time, want.epoch,
                     want.date.year, want.date.month, want.date.day,
                     want.date.hour, want.date.min, want.date.sec,
                     got.year, got.month, got.day, got.hour, got.min, got.sec);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        dates_due.push_back('{epoch_seconds_i, local_calendar(epoch_seconds_i, zone_offset)});
      if (cfg_we_i) zone_offset = cfg_wdata_i;
      pending = dates_due.size();
    end
  end

endmodule

### bench/epoch_to_calendar_date_unit_test.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the epoch-to-calendar converter. The checker
// instance beside the block does all prediction and comparison; this module
// only drives the channels, changes the zone offset between phases and
// decides pass or fail at the end.
module epoch_to_calendar_date_unit_test;

  // no item accepted on either channel for this long means the block is hung
  localparam int QuietLimit = 2000;
  localparam int NumPhases = 8;
  localparam int ItemsPerPhase = 220;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic signed [16:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        epoch_seconds = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [5:0]         second_of_minute;
  logic [5:0]         minute_of_hour;
  logic [4:0]         hour_of_day;
  logic [4:0]         day_of_month;
  logic [3:0]         month_number;
  logic [11:0]        year_number;
  int                 errors;
  int                 pending;
  int                 quiet_cycles = 0;

  epoch_to_calendar_date_unit uut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .epoch_seconds_i    (epoch_seconds),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .second_of_minute_o (second_of_minute),
    .minute_of_hour_o   (minute_of_hour),
    .hour_of_day_o      (hour_of_day),
    .day_of_month_o     (day_of_month),
    .month_number_o     (month_number),
    .year_number_o      (year_number)
  );

  calendar_date_checker checker_inst (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .epoch_seconds_i    (epoch_seconds),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .second_of_minute_i (second_of_minute),
    .minute_of_hour_i   (minute_of_hour),
    .hour_of_day_i      (hour_of_day),
    .day_of_month_i     (day_of_month),
    .month_number_i     (month_number),
    .year_number_i      (year_number),
    .errors_o           (errors),
    .pending_o          (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Present one item from the falling edge and hold it until taken. Valid
  // is left high so that a following call gives a back-to-back item.
  task automatic send_epoch(input logic [31:0] value);
    @(negedge clk);
    in_valid = 1'b1;
    epoch_seconds = value;
    do @(posedge clk); while (in_stall);
  endtask

  // gap in sending; payload is junk while valid is low
  task automatic idle_cycles(input int n);
    @(negedge clk);
    in_valid = 1'b0;
    epoch_seconds = $urandom;
    repeat (n - 1) @(negedge clk);
  endtask

  // Receiver back-pressure: alternates between free flow, light and heavy
  // random stalling and a fixed 3-in-7 pattern, each for a random span, so
  // stalls land on every pipeline phase.
  initial begin : receiver
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      for (int j = 0; j < span; j++) begin
        @(negedge clk);
        case (mode)
          0:       out_stall = 1'b0;
          1:       out_stall = ($urandom_range(0, 3) == 0);
          2:       out_stall = ($urandom_range(0, 3) != 0);
          default: out_stall = ((j % 7) < 3);
        endcase
      end
    end
  end

  // hang detector
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no progress for %0d cycles", $time, QuietLimit);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] e;
    int unsigned day_no;
    int          off;
    int          burst;
    burst = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed corners under the reset offset (UTC+8, so local midnight is
    // 28800 s before the UTC one): counter extremes incl. the wrap of the
    // sum, month and year ends, the leap day of 2000 and the 2100 leap day
    // that the every-fourth-year rule invents.
    for (int k = 0; k < 18; k++) begin
      case (k)
        0:  e = 32'd0;
        1:  e = 32'hFFFF_FFFF;
        2:  e = 32'd34185599;    // 1971-01-31 23:59:59 local
        3:  e = 32'd34185600;    // 1971-02-01
        4:  e = 32'd70905599;    // 1972-03-31 23:59:59, leap year
        5:  e = 32'd70905600;    // 1972-04-01
        6:  e = 32'd94665599;    // 1972-12-31 23:59:59, day 366
        7:  e = 32'd94665600;    // 1973-01-01
        8:  e = 32'd951753599;   // 2000-02-28 23:59:59
        9:  e = 32'd951753600;   // 2000-02-29 00:00:00
        10: e = 32'd951839999;   // 2000-02-29 23:59:59
        11: e = 32'd951840000;   // 2000-03-01
        12: e = 32'd4107513599;  // 2100-02-28 23:59:59
        13: e = 32'd4107513600;  // 2100-02-29, not a Gregorian date
        14: e = 32'd4107599999;
        15: e = 32'd4107600000;  // 2100-03-01 under the four-year rule
        16: e = 32'hAAAA_AAAA;
        default: e = 32'h5555_5555;
      endcase
      send_epoch(e);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph != 0) begin
        // drain before touching the offset
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        case (ph)
          1:       off = -43200;                // westmost legal zone
          2:       off = 50400;                 // eastmost legal zone
          3:       off = 0;
          4:       off = -65536;                // most negative 17-bit pattern
          5:       off = 65535;                 // most positive 17-bit pattern
          6:       off = int'($urandom_range(0, 93600)) - 43200;
          default: off = int'($urandom_range(0, 32'h1FFFF));
        endcase
        cfg_we = 1'b1;
        cfg_wdata = off[16:0];
        @(negedge clk);
        cfg_we = 1'b0;
        // both ends of the counter again, to hit the wrap under each offset
        send_epoch(32'd0);
        send_epoch(32'hFFFF_FFFF);
      end

      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (burst == 0) begin
          if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
          burst = $urandom_range(1, 40);
        end
        burst--;
        // biased towards the places where the date arithmetic turns over
        case ($urandom_range(0, 7))
          0: e = $urandom_range(0, 200000);
          1: e = 32'hFFFF_FFFF - $urandom_range(0, 200000);
          2: begin
            day_no = $urandom_range(0, 33) * 1461 + 789;  // leap day of the block
            e = day_no * 32'd86400 + $urandom_range(0, 345600) - 32'd172800;
          end
          3: begin
            day_no = $urandom_range(0, 33) * 1461;
            case ($urandom_range(0, 3))
              0:       day_no += 0;
              1:       day_no += 365;
              2:       day_no += 730;
              default: day_no += 1096;
            endcase
            e = day_no * 32'd86400 + $urandom_range(0, 345600) - 32'd172800;
          end
          default: e = $urandom;
        endcase
        send_epoch(e);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    // room for any stray item beyond the nine pipeline stages
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
